>>> design/stw_pkg.sv
`default_nettype none

package stw_pkg;

    // Default values of the top-level parameters
    localparam int ADDRESS_BITS_DEF        = 20;
    localparam int PHASE_FRACTION_BITS_DEF = 24;

    // Register field widths and reset values
    localparam int FREQ_W = 18;
    localparam int RATE_W = 18;
    localparam int LEN_W  = 20;

    localparam logic [FREQ_W-1:0] FREQ_RST = 18'd1840;
    localparam logic [RATE_W-1:0] RATE_RST = 18'd22050;
    localparam logic [LEN_W-1:0]  LEN_RST  = 20'd66150;

    // APB port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_TONE_FREQ   = 2'd0;
    localparam logic [1:0] REG_SAMPLE_RATE = 2'd1;
    localparam logic [1:0] REG_BUFFER_LEN  = 2'd2;

    // Divider step counter (enough for up to 32 quotient bits)
    localparam int STEPS_W = 6;

    // CORDIC: 32-bit turn angle, 2^30 amplitude scale
    localparam int ANGLE_W       = 32;
    localparam int CORDIC_W      = 34;
    localparam int CORDIC_STEPS  = 28;
    localparam int STEP_W        = 5;
    localparam int ATAN_W        = 30;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;
    localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

    // Output scaling: sample = trunc(y * 32760 / 2^30)
    localparam int SAMPLE_W     = 16;
    localparam int AMPLITUDE    = 32760;
    localparam int AMP_SHIFT_HI = 15;   // 32760 = 2^15 - 2^3
    localparam int AMP_SHIFT_LO = 3;
    localparam int SAMPLE_SHIFT = 30;

    // Input and result transactions
    typedef struct packed {
        logic             restart;
        logic [LEN_W-1:0] start_offset;
    } item_t;

    typedef struct packed {
        logic [LEN_W-1:0]           write_address;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic                       last;
    } result_t;

    // Divider control and status
    typedef struct packed {
        logic               start;
        logic [STEPS_W-1:0] steps;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // atan(2^-k) in units of 2^-32 turn
    function automatic logic [ATAN_W-1:0] atan_turn(input logic [STEP_W-1:0] k);
        logic [ATAN_W-1:0] v;
        unique case (k)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933405;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335086;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41721;
            5'd15:   v = 30'd20860;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2607;
            5'd19:   v = 30'd1303;
            5'd20:   v = 30'd651;
            5'd21:   v = 30'd325;
            5'd22:   v = 30'd162;
            5'd23:   v = 30'd81;
            5'd24:   v = 30'd40;
            5'd25:   v = 30'd20;
            5'd26:   v = 30'd10;
            5'd27:   v = 30'd5;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> design/stw_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The partial remainder starts
// at init_rem (must be below divisor) and ctrl.steps dividend bits are shifted
// in MSB first.
module stw_div
    import stw_pkg::*;
#(
    parameter int DW = 24
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire div_ctrl_t         ctrl,
    input  wire logic [RATE_W-1:0] init_rem,
    input  wire logic [DW-1:0]     dividend,
    input  wire logic [RATE_W-1:0] divisor,
    output unit_stat_t             stat,
    output logic [RATE_W-1:0]      rem,
    output logic [DW-1:0]          quot
);

    logic               busy_reg;
    logic               done_reg;
    logic [STEPS_W-1:0] cnt_reg;
    logic [RATE_W-1:0]  rem_reg;
    logic [DW-1:0]      dvd_reg;
    logic [DW-1:0]      quot_reg;

    logic [RATE_W:0] trial;
    logic [RATE_W:0] diff;
    logic            ge;

    // One trial subtraction
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DW-1]};
        diff  = trial - {1'b0, divisor};
        ge    = (trial >= {1'b0, divisor});
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= ctrl.steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEPS_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Remainder, dividend and quotient shift
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg  <= init_rem;
            dvd_reg  <= dividend;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
            dvd_reg  <= dvd_reg << 1;
            quot_reg <= {quot_reg[DW-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg;
    assign quot      = quot_reg;

endmodule

`default_nettype wire

>>> design/stw_cordic.sv
`default_nettype none

// Iterative CORDIC sine: one rotation step per cycle, then scaling to
// 32760 full scale with truncation toward zero.
module stw_cordic
    import stw_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [ANGLE_W-1:0] angle,
    output unit_stat_t              stat,
    output logic signed [SAMPLE_W-1:0] sample
);

    localparam int P_W = CORDIC_W + 16;
    localparam int Q_W = P_W - SAMPLE_SHIFT;

    typedef enum logic [2:0] {C_IDLE, C_ITER, C_SCALE, C_ABS, C_ROUND} cstate_t;

    cstate_t                    state_reg;
    logic [STEP_W-1:0]          k_reg;
    logic                       done_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [CORDIC_W-1:0] z_reg;
    logic signed [P_W-1:0]      p_reg;
    logic                       neg_reg;
    logic [Q_W-1:0]             q_reg;

    logic [ANGLE_W-1:0]         a_fold;
    logic signed [CORDIC_W-1:0] z_init;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [CORDIC_W-1:0] at;
    logic signed [P_W-1:0]      y_ext;
    logic signed [P_W-1:0]      p_calc;
    logic [P_W-1:0]             p_mag;
    logic [Q_W-1:0]             q_clamp;
    logic [SAMPLE_W-1:0]        c16;
    logic signed [SAMPLE_W-1:0] sample_calc;

    always_comb
    begin
        // Fold the second and third quadrant onto the first and fourth
        a_fold = (angle[ANGLE_W-1] ^ angle[ANGLE_W-2]) ? (HALF_TURN - angle) : angle;
        z_init = CORDIC_W'($signed(a_fold));

        // Rotation terms
        dx = y_reg >>> k_reg;
        dy = x_reg >>> k_reg;
        at = $signed({{(CORDIC_W-ATAN_W){1'b0}}, atan_turn(k_reg)});

        // y * 32760 as a shift-subtract
        y_ext  = P_W'(y_reg);
        p_calc = (y_ext <<< AMP_SHIFT_HI) - (y_ext <<< AMP_SHIFT_LO);

        // Magnitude, truncation and clamp
        p_mag   = p_reg[P_W-1] ? P_W'(-p_reg) : P_W'(p_reg);
        q_clamp = (q_reg > Q_W'(AMPLITUDE)) ? Q_W'(AMPLITUDE) : q_reg;
        c16     = q_clamp[SAMPLE_W-1:0];
        sample_calc = neg_reg ? -$signed(c16) : $signed(c16);
    end

    // Sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= C_IDLE;
            k_reg      <= '0;
            done_reg   <= 1'b0;
            sample_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        k_reg     <= '0;
                        state_reg <= C_ITER;
                    end
                end
                C_ITER:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == STEP_W'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= C_SCALE;
                    end
                end
                C_SCALE:
                begin
                    state_reg <= C_ABS;
                end
                C_ABS:
                begin
                    state_reg <= C_ROUND;
                end
                C_ROUND:
                begin
                    sample_reg <= sample_calc;
                    done_reg   <= 1'b1;
                    state_reg  <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && start)
        begin
            x_reg <= CORDIC_GAIN_INV;
            y_reg <= '0;
            z_reg <= z_init;
        end
        else if (state_reg == C_ITER)
        begin
            if (!z_reg[CORDIC_W-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
        if (state_reg == C_SCALE)
        begin
            p_reg <= p_calc;
        end
        if (state_reg == C_ABS)
        begin
            neg_reg <= p_reg[P_W-1];
            q_reg   <= p_mag[P_W-1:SAMPLE_SHIFT];
        end
    end

    assign stat.busy = (state_reg != C_IDLE);
    assign stat.done = done_reg;
    assign sample    = sample_reg;

endmodule

`default_nettype wire

>>> design/sine_tone_ring_writer.sv
`default_nettype none

// Sine tone ring writer. Each transaction on the item channel yields one
// result: a sample of 32760*sin(2*pi*f*i/fs), truncated toward zero to within
// one LSB, the ring buffer address it belongs at, and a last flag on sample
// length-1 of a run. restart=1 begins a new run at start_offset (taken as 0
// when not below the buffer length). One item is worked on at a time, and
// item_ready comes back in the same cycle as its result appears. The phase
// arithmetic uses a shared one-bit-per-cycle divider. It first reduces the
// phase remainder mod the sample rate (18 steps) and then forms the turn
// fraction (PHASE_FRACTION_BITS steps). Last it computes f mod fs while a
// 28-step CORDIC and its scaling run. Each unit is launched through a start
// register and then loads its operands, and the sequencer records the
// finished sine and f mod fs, leaves the wait and then writes the result.
// item_ready is high only between items. A finished result sits in an output
// register, so the next item can be taken while it waits. If a result is
// still waiting when the next one is ready, the sequencer holds that one and
// keeps item_ready low until the receiver takes the first. The registers
// (tone frequency at 0x0, sample rate at 0x4, buffer length at 0x8) must be
// written only while the block is idle; the block itself does not enforce
// this.
module sine_tone_ring_writer
    import stw_pkg::*;
#(
    parameter int ADDRESS_BITS        = ADDRESS_BITS_DEF,
    parameter int PHASE_FRACTION_BITS = PHASE_FRACTION_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // APB configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    // Item channel
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire item_t              item,
    // Result channel
    output logic                    result_valid,
    input  wire logic               result_ready,
    output result_t                 result
);

    localparam int AW = (ADDRESS_BITS < LEN_W) ? ADDRESS_BITS : LEN_W;
    localparam int DW = (PHASE_FRACTION_BITS > RATE_W) ? PHASE_FRACTION_BITS : RATE_W;

    typedef enum logic [2:0] {S_IDLE, S_MOD, S_TURN, S_SINE, S_WRITE} state_t;

    // Configuration registers
    logic [FREQ_W-1:0] freq_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [LEN_W-1:0]  len_reg;

    // Sequencer and run state
    state_t             state_reg;
    div_ctrl_t          div_ctrl_reg;
    logic [RATE_W-1:0]  div_init_reg;
    logic [DW-1:0]      div_dvd_reg;
    logic               cordic_start_reg;
    logic [ANGLE_W-1:0] angle_reg;
    logic [AW-1:0]      count_reg;
    logic [AW-1:0]      ring_reg;
    logic [AW-1:0]      offset_reg;
    logic [RATE_W-1:0]  phase_reg;
    logic [RATE_W-1:0]  fmod_reg;
    logic               sine_seen_reg;
    logic               fmod_seen_reg;
    logic               result_valid_reg;
    result_t            result_reg;

    // Unit connections
    unit_stat_t                 div_stat;
    logic [RATE_W-1:0]          div_rem;
    logic [DW-1:0]              div_quot;
    unit_stat_t                 cord_stat;
    logic signed [SAMPLE_W-1:0] cord_sample;

    // Working values
    logic              cfg_write;
    logic              item_take;
    logic [AW-1:0]     len_eff;
    logic [RATE_W-1:0] fs_eff;
    logic [AW-1:0]     off_in;
    logic [AW-1:0]     off_ok;
    logic [AW-1:0]     pos_base;
    logic [AW-1:0]     ring_next;
    logic [RATE_W-1:0] phase_base;
    logic              is_last;
    logic [AW-1:0]     ring_adv;
    logic [AW-1:0]     ring_step;
    logic [AW-1:0]     ring_restart;
    logic [RATE_W:0]   phase_sum;
    logic [RATE_W-1:0] phase_step;
    logic              out_free;

    stw_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl_reg),
        .init_rem (div_init_reg),
        .dividend (div_dvd_reg),
        .divisor  (fs_eff),
        .stat     (div_stat),
        .rem      (div_rem),
        .quot     (div_quot)
    );

    stw_cordic u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cordic_start_reg),
        .angle  (angle_reg),
        .stat   (cord_stat),
        .sample (cord_sample)
    );

    // Configuration registers
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= FREQ_RST;
            rate_reg <= RATE_RST;
            len_reg  <= LEN_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_TONE_FREQ:   freq_reg <= pwdata[FREQ_W-1:0];
                REG_SAMPLE_RATE: rate_reg <= pwdata[RATE_W-1:0];
                REG_BUFFER_LEN:  len_reg  <= pwdata[LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TONE_FREQ:   prdata = PDATA_W'(freq_reg);
            REG_SAMPLE_RATE: prdata = PDATA_W'(rate_reg);
            REG_BUFFER_LEN:  prdata = PDATA_W'(len_reg);
            default:         prdata = '0;
        endcase
    end

    // Run bookkeeping
    always_comb
    begin
        len_eff    = (len_reg[AW-1:0] == '0) ? AW'(1) : len_reg[AW-1:0];
        fs_eff     = (rate_reg == '0) ? RATE_W'(1) : rate_reg;

        // Restart and wrap of the current position
        off_in     = item.start_offset[AW-1:0];
        off_ok     = (off_in >= len_eff) ? '0 : off_in;
        pos_base   = item.restart ? off_ok : ring_reg;
        ring_next  = (pos_base >= len_eff) ? '0 : pos_base;
        phase_base = item.restart ? '0 : phase_reg;

        // Advance after the sample
        is_last      = (count_reg >= len_eff - 1'b1);
        ring_adv     = ring_reg + 1'b1;
        ring_step    = (ring_adv >= len_eff) ? '0 : ring_adv;
        ring_restart = (offset_reg < len_eff) ? offset_reg : '0;
        phase_sum    = {1'b0, phase_reg} + {1'b0, fmod_reg};
        phase_step   = (phase_sum >= {1'b0, fs_eff}) ?
                       RATE_W'(phase_sum - {1'b0, fs_eff}) : phase_sum[RATE_W-1:0];
    end

    assign item_ready = (state_reg == S_IDLE);
    assign item_take  = item_valid && item_ready;
    assign out_free   = !result_valid_reg || result_ready;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            div_ctrl_reg     <= '0;
            div_init_reg     <= '0;
            div_dvd_reg      <= '0;
            cordic_start_reg <= 1'b0;
            angle_reg        <= '0;
            count_reg        <= '0;
            ring_reg         <= '0;
            offset_reg       <= '0;
            phase_reg        <= '0;
            fmod_reg         <= '0;
            sine_seen_reg    <= 1'b0;
            fmod_seen_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            div_ctrl_reg.start <= 1'b0;
            cordic_start_reg   <= 1'b0;
            if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_take)
                    begin
                        ring_reg <= ring_next;
                        if (item.restart)
                        begin
                            offset_reg <= off_ok;
                            count_reg  <= '0;
                        end
                        // phase remainder mod fs
                        div_ctrl_reg.start <= 1'b1;
                        div_ctrl_reg.steps <= STEPS_W'(RATE_W);
                        div_init_reg       <= '0;
                        div_dvd_reg        <= DW'(phase_base) << (DW - RATE_W);
                        state_reg          <= S_MOD;
                    end
                end
                S_MOD:
                begin
                    if (div_stat.done)
                    begin
                        // turn fraction = remainder * 2^P / fs
                        phase_reg          <= div_rem;
                        div_ctrl_reg.start <= 1'b1;
                        div_ctrl_reg.steps <= STEPS_W'(PHASE_FRACTION_BITS);
                        div_init_reg       <= div_rem;
                        div_dvd_reg        <= '0;
                        state_reg          <= S_TURN;
                    end
                end
                S_TURN:
                begin
                    if (div_stat.done)
                    begin
                        angle_reg <= ANGLE_W'(div_quot[PHASE_FRACTION_BITS-1:0])
                                     << (ANGLE_W - PHASE_FRACTION_BITS);
                        cordic_start_reg   <= 1'b1;
                        // f mod fs runs beside the CORDIC
                        div_ctrl_reg.start <= 1'b1;
                        div_ctrl_reg.steps <= STEPS_W'(RATE_W);
                        div_init_reg       <= '0;
                        div_dvd_reg        <= DW'(freq_reg) << (DW - FREQ_W);
                        sine_seen_reg      <= 1'b0;
                        fmod_seen_reg      <= 1'b0;
                        state_reg          <= S_SINE;
                    end
                end
                S_SINE:
                begin
                    if (cord_stat.done)
                    begin
                        sine_seen_reg <= 1'b1;
                    end
                    if (div_stat.done)
                    begin
                        fmod_reg      <= div_rem;
                        fmod_seen_reg <= 1'b1;
                    end
                    if (sine_seen_reg && fmod_seen_reg)
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (out_free)
                    begin
                        result_reg.write_address <= LEN_W'(ring_reg);
                        result_reg.sample_value  <= cord_sample;
                        result_reg.last          <= is_last;
                        result_valid_reg         <= 1'b1;
                        if (is_last)
                        begin
                            count_reg <= '0;
                            ring_reg  <= ring_restart;
                            phase_reg <= '0;
                        end
                        else
                        begin
                            count_reg <= count_reg + 1'b1;
                            ring_reg  <= ring_step;
                            phase_reg <= phase_step;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted while a previous item was still in work");

    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.sample_value <= 16'sd32760 &&
                          result.sample_value >= -16'sd32760))
        else $error("sample outside full scale");

    a_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> (!div_stat.busy && !cord_stat.busy))
        else $error("arithmetic unit busy while idle");

    a_write_complete: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WRITE |-> (sine_seen_reg && fmod_seen_reg))
        else $error("result written before sine and phase step were ready");
`endif

endmodule

`default_nettype wire
